/* hdl/lgg_pkg.sv */
// shared types, register codes and helper functions for the gamma table generator
// no dependencies; used by lift_gamma_gain_lut_gen
package lgg_pkg;

   // number of bit steps in the divider, the log2 unit and the exp2 unit
   localparam int unsigned ITER_STEPS = 30;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_GAMMA_EXP     = 3'd0,
      CSR_LIFT_OFFSET   = 3'd1,
      CSR_GAIN_SCALE    = 3'd2,
      CSR_RED_MULT      = 3'd3,
      CSR_GREEN_MULT    = 3'd4,
      CSR_BLUE_MULT     = 3'd5,
      CSR_TABLE_ENTRIES = 3'd6
   } csr_index_type;

   // sideband that follows each transaction down the pipe
   typedef struct packed {
      logic [11:0] idx;
      logic        pos;
   } tag_type;

   // divider stage contents
   typedef struct packed {
      tag_type            tag;
      logic signed [6:0]  expo;
      logic [31:0]        dvs;
      logic [31:0]        rem;
      logic [30:0]        quo;
   } div_type;

   // log2 stage contents
   typedef struct packed {
      tag_type            tag;
      logic signed [6:0]  expo;
      logic [29:0]        frac;
      logic [30:0]        mant;
   } log_type;

   // exp2 stage contents
   typedef struct packed {
      tag_type     tag;
      logic [8:0]  ip;
      logic        neg;
      logic        zero;
      logic        exact;
      logic [29:0] f;
      logic [30:0] r;
   } exp_type;

   // leading zero count of a 32 bit word, 32 when the word is zero
   function automatic logic [5:0] lzc32(input logic [31:0] v);
      logic [5:0] n;
      n = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) n = 6'(31 - i);
      end
      return n;
   endfunction

   // integer square root, used only at elaboration
   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] b;
      v = v_in;
      res = '0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // k-th successive square root of two in Q30, k = 0 gives sqrt(2)
   function automatic logic [30:0] root_const(input int k);
      logic [63:0] s;
      s = isqrt64(64'd2 << 60);
      for (int i = 1; i < 30; i++) begin
         if (i <= k) s = isqrt64(s << 30);
      end
      return 31'(s);
   endfunction

   // channel level from the scaled product, clamp to one then round to 16 bits
   function automatic logic [15:0] to_level(input logic [45:0] prod);
      logic [33:0] t;
      logic [32:0] c;
      logic [48:0] acc;
      t = prod[45:12];
      c = (t > 34'h1_0000_0000) ? 33'h1_0000_0000 : t[32:0];
      acc = {c, 16'b0} - {16'b0, c} + 49'h0_8000_0000;
      return acc[47:32];
   endfunction

endpackage

/* hdl/lift_gamma_gain_lut_gen.sv */
// lift/gamma/gain table entry generator, fully pipelined
// throughput: one transaction per cycle; a stall on rsp freezes the whole pipe
// the depth is set by the 30 step divider, 30 step log2 and 30 step exp2 chains
// reset: synchronous, clears all valid bits and loads the registers' defaults
// depends on lgg_pkg
module lift_gamma_gain_lut_gen #(
   parameter int unsigned MAX_ENTRIES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_entry_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_entry_out,
   output logic [15:0] rsp_red_level,
   output logic [15:0] rsp_green_level,
   output logic [15:0] rsp_blue_level,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int unsigned STEPS = lgg_pkg::ITER_STEPS;
   localparam logic [16:0] MAX_N = 17'(MAX_ENTRIES);

   // configuration registers
   logic [14:0]        gamma_exp_ff;
   logic signed [12:0] lift_offset_ff;
   logic [12:0]        gain_scale_ff, red_mult_ff, green_mult_ff, blue_mult_ff;
   logic [12:0]        table_entries_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_exp_ff     <= 15'd4096;
         lift_offset_ff   <= 13'sd0;
         gain_scale_ff    <= 13'd4096;
         red_mult_ff      <= 13'd4096;
         green_mult_ff    <= 13'd4096;
         blue_mult_ff     <= 13'd4096;
         table_entries_ff <= 13'd256;
      end else if (csr_valid) begin
         unique case (csr_index)
            lgg_pkg::CSR_GAMMA_EXP:     gamma_exp_ff     <= csr_data[14:0];
            lgg_pkg::CSR_LIFT_OFFSET:   lift_offset_ff   <= $signed(csr_data[12:0]);
            lgg_pkg::CSR_GAIN_SCALE:    gain_scale_ff    <= csr_data[12:0];
            lgg_pkg::CSR_RED_MULT:      red_mult_ff      <= csr_data[12:0];
            lgg_pkg::CSR_GREEN_MULT:    green_mult_ff    <= csr_data[12:0];
            lgg_pkg::CSR_BLUE_MULT:     blue_mult_ff     <= csr_data[12:0];
            lgg_pkg::CSR_TABLE_ENTRIES: table_entries_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // global advance: everything moves when the output slot is free or taken
   logic en;
   logic rsp_valid_ff;
   assign en = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // stage 1: table size clamp and index saturation
   logic [16:0] n17, n_use;
   logic [12:0] s1_nm1_in, s1_nm1_ff;
   logic [11:0] s1_idx_in, s1_idx_ff;
   logic        s1_vld_ff;

   assign n17 = {4'b0, table_entries_ff};
   assign n_use = (n17 < 17'd2) ? 17'd2 : ((n17 > MAX_N) ? MAX_N : n17);
   assign s1_nm1_in = 13'(n_use - 17'd1);
   assign s1_idx_in = ({1'b0, req_entry_index} > s1_nm1_in) ? s1_nm1_in[11:0]
                                                           : req_entry_index;

   // stage 2: numerator idx*4096 + lift*(n-1)
   logic signed [26:0] lift_term, s2_num_in, s2_num_ff;
   logic [12:0]        s2_nm1_ff;
   logic [11:0]        s2_idx_ff;
   logic               s2_vld_ff;

   assign lift_term = $signed({{14{lift_offset_ff[12]}}, lift_offset_ff})
                    * $signed({14'b0, s1_nm1_ff});
   assign s2_num_in = $signed({3'b0, s1_idx_ff, 12'b0}) + lift_term;

   // stage 3: sign test and leading zero counts
   lgg_pkg::tag_type s3_tag_in, s3_tag_ff;
   logic [25:0]      s3_un_ff;
   logic [12:0]      s3_nm1_ff;
   logic [5:0]       s3_lzu_in, s3_lzu_ff, s3_lzn_in, s3_lzn_ff;
   logic             s3_vld_ff;

   assign s3_tag_in.idx = s2_idx_ff;
   assign s3_tag_in.pos = !s2_num_ff[26] && (s2_num_ff != 27'sd0);
   assign s3_lzu_in = lgg_pkg::lzc32({6'b0, s2_num_ff[25:0]});
   assign s3_lzn_in = lgg_pkg::lzc32({19'b0, s2_nm1_ff});

   // stage 4: normalize numerator and divisor to 32 bits
   lgg_pkg::tag_type  s4_tag_ff;
   logic [31:0]       s4_u_in, s4_u_ff, s4_d_in, s4_d_ff;
   logic signed [6:0] s4_epre_in, s4_epre_ff;
   logic              s4_vld_ff;

   assign s4_u_in = {6'b0, s3_un_ff} << s3_lzu_ff[4:0];
   assign s4_d_in = {19'b0, s3_nm1_ff} << s3_lzn_ff[4:0];
   assign s4_epre_in = $signed(7'({1'b0, s3_lzn_ff}) - 7'({1'b0, s3_lzu_ff}) - 7'd12);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_nm1_ff  <= s1_nm1_in;
         s1_idx_ff  <= s1_idx_in;
         s2_num_ff  <= s2_num_in;
         s2_nm1_ff  <= s1_nm1_ff;
         s2_idx_ff  <= s1_idx_ff;
         s3_tag_ff  <= s3_tag_in;
         s3_un_ff   <= s2_num_ff[25:0];
         s3_nm1_ff  <= s2_nm1_ff;
         s3_lzu_ff  <= s3_lzu_in;
         s3_lzn_ff  <= s3_lzn_in;
         s4_tag_ff  <= s3_tag_ff;
         s4_u_ff    <= s4_u_in;
         s4_d_ff    <= s4_d_in;
         s4_epre_ff <= s4_epre_in;
      end
   end

   // divider: first quotient bit and exponent fixup, then one bit per stage
   lgg_pkg::div_type div_ff [0:STEPS];
   logic             div_vld_ff [0:STEPS];
   lgg_pkg::div_type div0_in;
   logic             div0_ge;
   logic [32:0]      div0_wide;

   assign div0_ge = s4_u_ff >= s4_d_ff;
   assign div0_wide = div0_ge ? {1'b0, s4_u_ff} : {s4_u_ff, 1'b0};
   assign div0_in.tag = s4_tag_ff;
   assign div0_in.expo = div0_ge ? s4_epre_ff : (s4_epre_ff - 7'sd1);
   assign div0_in.dvs = s4_d_ff;
   assign div0_in.rem = 32'(div0_wide - {1'b0, s4_d_ff});
   assign div0_in.quo = 31'd1;

   always_ff @(posedge clock) begin
      if (reset) div_vld_ff[0] <= 1'b0;
      else if (en) div_vld_ff[0] <= s4_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) div_ff[0] <= div0_in;
   end

   for (genvar k = 1; k <= STEPS; k++) begin : g_div
      lgg_pkg::div_type div_in;
      logic [32:0]      r2;
      logic             b;
      assign r2 = {div_ff[k-1].rem, 1'b0};
      assign b = r2 >= {1'b0, div_ff[k-1].dvs};
      assign div_in.tag = div_ff[k-1].tag;
      assign div_in.expo = div_ff[k-1].expo;
      assign div_in.dvs = div_ff[k-1].dvs;
      assign div_in.rem = b ? 32'(r2 - {1'b0, div_ff[k-1].dvs}) : r2[31:0];
      assign div_in.quo = {div_ff[k-1].quo[29:0], b};

      always_ff @(posedge clock) begin
         if (reset) div_vld_ff[k] <= 1'b0;
         else if (en) div_vld_ff[k] <= div_vld_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (en) div_ff[k] <= div_in;
      end
   end

   // log2 of the mantissa by repeated squaring, one fraction bit per stage
   lgg_pkg::log_type log_ff  [1:STEPS];
   logic             log_vld_ff [1:STEPS];
   lgg_pkg::log_type log_src [0:STEPS];
   logic             log_vld_src [0:STEPS];

   assign log_src[0].tag = div_ff[STEPS].tag;
   assign log_src[0].expo = div_ff[STEPS].expo;
   assign log_src[0].frac = '0;
   assign log_src[0].mant = div_ff[STEPS].quo;
   assign log_vld_src[0] = div_vld_ff[STEPS];

   for (genvar k = 1; k <= STEPS; k++) begin : g_log
      lgg_pkg::log_type log_in;
      logic [61:0]      sq;
      logic [31:0]      m2;
      assign sq = 62'(log_src[k-1].mant) * 62'(log_src[k-1].mant);
      assign m2 = sq[61:30];
      assign log_in.tag = log_src[k-1].tag;
      assign log_in.expo = log_src[k-1].expo;
      assign log_in.frac = {log_src[k-1].frac[28:0], m2[31]};
      assign log_in.mant = m2[31] ? m2[31:1] : m2[30:0];
      assign log_src[k] = log_ff[k];
      assign log_vld_src[k] = log_vld_ff[k];

      always_ff @(posedge clock) begin
         if (reset) log_vld_ff[k] <= 1'b0;
         else if (en) log_vld_ff[k] <= log_vld_src[k-1];
      end

      always_ff @(posedge clock) begin
         if (en) log_ff[k] <= log_in;
      end
   end

   // log value to sign and magnitude
   lgg_pkg::tag_type   lv_tag_ff;
   logic signed [36:0] lv_val;
   logic [35:0]        lv_mag_in, lv_mag_ff;
   logic               lv_neg_ff, lv_vld_ff;

   assign lv_val = $signed({log_src[STEPS].expo, log_src[STEPS].frac});
   assign lv_mag_in = lv_val[36] ? 36'(-lv_val) : lv_val[35:0];

   // gamma times magnitude as two partial products
   lgg_pkg::tag_type pp_tag_ff;
   logic [32:0]      pp_lo_in, pp_lo_ff, pp_hi_in, pp_hi_ff;
   logic             pp_neg_ff, pp_vld_ff;

   assign pp_lo_in = 33'(gamma_exp_ff) * 33'(lv_mag_ff[17:0]);
   assign pp_hi_in = 33'(gamma_exp_ff) * 33'(lv_mag_ff[35:18]);

   // partial product sum, integer and fraction of the scaled log
   lgg_pkg::tag_type sm_tag_ff;
   logic [50:0]      sm_sum;
   logic [8:0]       sm_ip_ff;
   logic [29:0]      sm_fr_ff;
   logic             sm_neg_ff, sm_vld_ff;

   assign sm_sum = {18'b0, pp_lo_ff} + {pp_hi_ff, 18'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_vld_ff <= 1'b0;
         pp_vld_ff <= 1'b0;
         sm_vld_ff <= 1'b0;
      end else if (en) begin
         lv_vld_ff <= log_vld_src[STEPS];
         pp_vld_ff <= lv_vld_ff;
         sm_vld_ff <= pp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lv_tag_ff <= log_src[STEPS].tag;
         lv_mag_ff <= lv_mag_in;
         lv_neg_ff <= lv_val[36];
         pp_tag_ff <= lv_tag_ff;
         pp_lo_ff  <= pp_lo_in;
         pp_hi_ff  <= pp_hi_in;
         pp_neg_ff <= lv_neg_ff;
         sm_tag_ff <= pp_tag_ff;
         sm_ip_ff  <= sm_sum[50:42];
         sm_fr_ff  <= sm_sum[41:12];
         sm_neg_ff <= pp_neg_ff;
      end
   end

   // exp2 of the fraction as a product of successive roots of two
   lgg_pkg::exp_type exp_ff [0:STEPS];
   logic             exp_vld_ff [0:STEPS];
   lgg_pkg::exp_type exp0_in;

   assign exp0_in.tag = sm_tag_ff;
   assign exp0_in.ip = sm_ip_ff;
   assign exp0_in.neg = sm_neg_ff;
   assign exp0_in.zero = sm_neg_ff && (sm_ip_ff >= 9'd40);
   assign exp0_in.exact = sm_neg_ff && (sm_fr_ff == 30'd0);
   assign exp0_in.f = sm_neg_ff ? (30'd0 - sm_fr_ff) : sm_fr_ff;
   assign exp0_in.r = 31'h4000_0000;

   always_ff @(posedge clock) begin
      if (reset) exp_vld_ff[0] <= 1'b0;
      else if (en) exp_vld_ff[0] <= sm_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) exp_ff[0] <= exp0_in;
   end

   for (genvar k = 1; k <= STEPS; k++) begin : g_exp
      localparam logic [30:0] ROOT = lgg_pkg::root_const(k - 1);
      lgg_pkg::exp_type exp_in;
      logic [61:0]      prod;
      assign prod = 62'(exp_ff[k-1].r) * 62'(ROOT);
      always_comb begin
         exp_in = exp_ff[k-1];
         if (exp_ff[k-1].f[STEPS-k]) exp_in.r = prod[60:30];
      end

      always_ff @(posedge clock) begin
         if (reset) exp_vld_ff[k] <= 1'b0;
         else if (en) exp_vld_ff[k] <= exp_vld_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (en) exp_ff[k] <= exp_in;
      end
   end

   // power: scale the exp2 result by the integer part
   lgg_pkg::tag_type pw_tag_ff;
   logic [39:0]      pw_p_in, pw_p_ff;
   logic             pw_vld_ff;

   always_comb begin
      if (!exp_ff[STEPS].neg) begin
         pw_p_in = 40'(exp_ff[STEPS].r) << (exp_ff[STEPS].ip + 9'd2);
      end else if (exp_ff[STEPS].zero) begin
         pw_p_in = '0;
      end else if (exp_ff[STEPS].exact) begin
         pw_p_in = 40'h01_0000_0000 >> exp_ff[STEPS].ip;
      end else begin
         pw_p_in = {7'b0, exp_ff[STEPS].r, 2'b00} >> (exp_ff[STEPS].ip + 9'd1);
      end
   end

   // gain product
   lgg_pkg::tag_type yp_tag_ff;
   logic [52:0]      yp_prod_in, yp_prod_ff;
   logic             yp_vld_ff;

   assign yp_prod_in = 53'(pw_p_ff) * 53'(gain_scale_ff);

   // clamp y to one, zero when the base was not positive
   lgg_pkg::tag_type yc_tag_ff;
   logic [40:0]      yc_t;
   logic [32:0]      yc_y_in, yc_y_ff;
   logic             yc_vld_ff;

   assign yc_t = yp_prod_ff[52:12];
   assign yc_y_in = !yp_tag_ff.pos ? 33'd0
                  : ((yc_t > 41'h1_0000_0000) ? 33'h1_0000_0000 : yc_t[32:0]);

   // per channel multiplier products
   lgg_pkg::tag_type cp_tag_ff;
   logic [45:0]      cp_r_in, cp_r_ff, cp_g_in, cp_g_ff, cp_b_in, cp_b_ff;
   logic             cp_vld_ff;

   assign cp_r_in = 46'(yc_y_ff) * 46'(red_mult_ff);
   assign cp_g_in = 46'(yc_y_ff) * 46'(green_mult_ff);
   assign cp_b_in = 46'(yc_y_ff) * 46'(blue_mult_ff);

   // output register: clamp and round each channel
   logic [11:0] rsp_entry_ff;
   logic [15:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_vld_ff    <= 1'b0;
         yp_vld_ff    <= 1'b0;
         yc_vld_ff    <= 1'b0;
         cp_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         pw_vld_ff    <= exp_vld_ff[STEPS];
         yp_vld_ff    <= pw_vld_ff;
         yc_vld_ff    <= yp_vld_ff;
         cp_vld_ff    <= yc_vld_ff;
         rsp_valid_ff <= cp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pw_tag_ff    <= exp_ff[STEPS].tag;
         pw_p_ff      <= pw_p_in;
         yp_tag_ff    <= pw_tag_ff;
         yp_prod_ff   <= yp_prod_in;
         yc_tag_ff    <= yp_tag_ff;
         yc_y_ff      <= yc_y_in;
         cp_tag_ff    <= yc_tag_ff;
         cp_r_ff      <= cp_r_in;
         cp_g_ff      <= cp_g_in;
         cp_b_ff      <= cp_b_in;
         rsp_entry_ff <= cp_tag_ff.idx;
         rsp_red_ff   <= lgg_pkg::to_level(cp_r_ff);
         rsp_green_ff <= lgg_pkg::to_level(cp_g_ff);
         rsp_blue_ff  <= lgg_pkg::to_level(cp_b_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_out   = rsp_entry_ff;
   assign rsp_red_level   = rsp_red_ff;
   assign rsp_green_level = rsp_green_ff;
   assign rsp_blue_level  = rsp_blue_ff;

endmodule

/* dv/tb_lift_gamma_gain_lut_gen.sv */
// self-checking testbench for the lift/gamma/gain table entry generator
// a directed table walk, then random config phases and random entries; depends on lgg_pkg
module tb_lift_gamma_gain_lut_gen;

   localparam int unsigned MAX_ENTRIES = 4096;
   localparam int unsigned PIPE_WAIT = 120;
   localparam logic [2:0] CSR_UNUSED = 3'd7;
   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
   localparam logic [63:0] ONE_Q32 = 64'd1 << 32;

   typedef struct {
      logic [11:0] entry;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } gamma_entry_type;

   typedef struct {
      bit              is_cfg;
      logic [2:0]      cidx;
      logic [15:0]     cdata;
      logic [11:0]     idx;
      bit              known;
      gamma_entry_type want;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [11:0] req_entry_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [11:0] rsp_entry_out;
   logic [15:0] rsp_red_level;
   logic [15:0] rsp_green_level;
   logic [15:0] rsp_blue_level;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   // local copy of the register file
   logic [14:0]        cur_gamma;
   logic signed [12:0] cur_lift;
   logic [12:0]        cur_gain;
   logic [12:0]        cur_red;
   logic [12:0]        cur_green;
   logic [12:0]        cur_blue;
   logic [12:0]        cur_entries;

   logic [63:0]     sqrt2_chain [0:29];
   gamma_entry_type pending_entries [$];
   table_row_type   directed_rows [$];
   int              fail_count = 0;
   bit              idle_on = 1'b1;

   lift_gamma_gain_lut_gen #(.MAX_ENTRIES(MAX_ENTRIES)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_entry_index(req_entry_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_entry_out(rsp_entry_out),
      .rsp_red_level(rsp_red_level), .rsp_green_level(rsp_green_level),
      .rsp_blue_level(rsp_blue_level),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #(12 * 3000000);
      $display("lift_gamma_gain_lut_gen test failed");
      $finish;
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] b;
      v = v_in;
      res = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic int bit_len(input logic [63:0] v);
      int n;
      n = 0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) n = i + 1;
      end
      return n;
   endfunction

   // log2 of a Q30 mantissa in [1,2), by repeated squaring
   function automatic logic [63:0] log2_q30(input logic [63:0] m_in);
      logic [63:0] m;
      logic [63:0] frac;
      m = m_in;
      frac = '0;
      for (int k = 1; k <= 30; k++) begin
         m = (m * m) >> 30;
         if (m >= (ONE_Q30 << 1)) begin
            m = m >> 1;
            frac[30 - k] = 1'b1;
         end
      end
      return frac;
   endfunction

   // 2^f for a Q30 fraction, product of successive roots of two
   function automatic logic [63:0] exp2_q30(input logic [63:0] f);
      logic [63:0] r;
      r = ONE_Q30;
      for (int k = 1; k <= 30; k++) begin
         if (f[30 - k]) r = (r * sqrt2_chain[k - 1]) >> 30;
      end
      return r;
   endfunction

   function automatic logic [15:0] channel_level(input logic [63:0] y, input logic [12:0] mult);
      logic [63:0] c;
      logic [63:0] acc;
      c = (y * 64'(mult)) >> 12;
      if (c > ONE_Q32) c = ONE_Q32;
      acc = (c * 64'd65535 + (64'd1 << 31)) >> 32;
      return acc[15:0];
   endfunction

   // expected table entry for one index under the current registers
   function automatic gamma_entry_type gamma_entry(input logic [11:0] idx_in);
      gamma_entry_type e;
      longint n;
      longint idx;
      longint num;
      logic [63:0] den;
      logic [63:0] un;
      logic [63:0] q;
      logic [63:0] m;
      logic [63:0] mag;
      logic [63:0] tm;
      logic [63:0] ip;
      logic [63:0] fr;
      logic [63:0] p;
      logic [63:0] y;
      longint lv;
      int s;
      int h;
      n = longint'(cur_entries);
      if (n < 2) n = 2;
      if (n > MAX_ENTRIES) n = MAX_ENTRIES;
      idx = longint'(idx_in);
      if (idx > n - 1) idx = n - 1;
      num = idx * 4096 + longint'(cur_lift) * (n - 1);
      den = 64'(4096 * (n - 1));
      y = '0;
      if (num > 0) begin
         un = 64'(num);
         s = 62 - bit_len(un);
         q = (un << s) / den;
         h = bit_len(q) - 1;
         m = q >> (h - 30);
         lv = longint'(h - s) * longint'(ONE_Q30) + longint'(log2_q30(m));
         mag = (lv < 0) ? 64'(-lv) : 64'(lv);
         tm = (64'(cur_gamma) * mag) >> 12;
         ip = tm >> 30;
         fr = tm & (ONE_Q30 - 1);
         if (lv >= 0) p = exp2_q30(fr) << (ip + 2);
         else if (ip >= 40) p = '0;
         else if (fr == 0) p = ONE_Q32 >> ip;
         else p = (exp2_q30(ONE_Q30 - fr) << 2) >> (ip + 1);
         y = (p * 64'(cur_gain)) >> 12;
         if (y > ONE_Q32) y = ONE_Q32;
      end
      e.entry = 12'(idx);
      e.red = channel_level(y, cur_red);
      e.green = channel_level(y, cur_green);
      e.blue = channel_level(y, cur_blue);
      return e;
   endfunction

   function automatic void apply_csr(input logic [2:0] index, input logic [15:0] data);
      case (index)
         lgg_pkg::CSR_GAMMA_EXP:     cur_gamma = data[14:0];
         lgg_pkg::CSR_LIFT_OFFSET:   cur_lift = data[12:0];
         lgg_pkg::CSR_GAIN_SCALE:    cur_gain = data[12:0];
         lgg_pkg::CSR_RED_MULT:      cur_red = data[12:0];
         lgg_pkg::CSR_GREEN_MULT:    cur_green = data[12:0];
         lgg_pkg::CSR_BLUE_MULT:     cur_blue = data[12:0];
         lgg_pkg::CSR_TABLE_ENTRIES: cur_entries = data[12:0];
         default: ;
      endcase
   endfunction

   function automatic void add_cfg_row(input logic [2:0] index, input logic [15:0] data);
      table_row_type r;
      r = '{default: '0};
      r.is_cfg = 1'b1;
      r.cidx = index;
      r.cdata = data;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_item_row(input logic [11:0] idx, input bit known,
                                        input logic [11:0] entry, input logic [15:0] lvl);
      table_row_type r;
      r = '{default: '0};
      r.idx = idx;
      r.known = known;
      r.want.entry = entry;
      r.want.red = lvl;
      r.want.green = lvl;
      r.want.blue = lvl;
      directed_rows.push_back(r);
   endfunction

   // one entry transaction; valid stays up across back-to-back items
   task automatic send_entry(input logic [11:0] idx, input bit known,
                             input gamma_entry_type want);
      while (idle_on && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_entry_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_entries.push_back(known ? want : gamma_entry(idx));
   endtask

   // wait for every pending result, then let the pipe empty
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (PIPE_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_q12(input int lo, input int hi, input int mode);
      if (mode == 0) return 16'(lo);
      if (mode == 1) return 16'(hi);
      if ($urandom_range(99) < 5) return 16'($urandom);
      return 16'($urandom_range(hi, lo));
   endfunction

   // result side stall pattern
   always @(posedge clock) begin
      rsp_ready <= idle_on ? ($urandom_range(99) >= 36) : 1'b1;
   end

   // result checker
   always @(posedge clock) begin
      gamma_entry_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_entries.size() == 0) begin
            $display("%0t unexpected result entry %0d", $time, rsp_entry_out);
            fail_count++;
         end else begin
            w = pending_entries.pop_front();
            if (rsp_entry_out !== w.entry) begin
               $display("%0t entry_out expected %0d actual %0d", $time, w.entry, rsp_entry_out);
               fail_count++;
            end
            if (rsp_red_level !== w.red) begin
               $display("%0t red_level expected %0d actual %0d", $time, w.red, rsp_red_level);
               fail_count++;
            end
            if (rsp_green_level !== w.green) begin
               $display("%0t green_level expected %0d actual %0d", $time, w.green,
                        rsp_green_level);
               fail_count++;
            end
            if (rsp_blue_level !== w.blue) begin
               $display("%0t blue_level expected %0d actual %0d", $time, w.blue, rsp_blue_level);
               fail_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      table_row_type row;
      logic [63:0] s;
      int n;
      int mode;
      logic [11:0] idx;
      s = int_sqrt(64'd2 << 60);
      for (int k = 0; k < 30; k++) begin
         sqrt2_chain[k] = s;
         s = int_sqrt(s << 30);
      end
      cur_gamma = 15'd4096;
      cur_lift = '0;
      cur_gain = 13'd4096;
      cur_red = 13'd4096;
      cur_green = 13'd4096;
      cur_blue = 13'd4096;
      cur_entries = 13'd256;

      // directed table: reset state, extremes and each special case
      add_item_row(12'd0, 1, 12'd0, 16'd0);
      add_item_row(12'd255, 1, 12'd255, 16'd65535);
      add_item_row(12'd4095, 1, 12'd255, 16'd65535);
      add_item_row(12'd128, 0, '0, '0);
      add_cfg_row(lgg_pkg::CSR_GAMMA_EXP, 16'd819);
      add_item_row(12'd1, 0, '0, '0);
      add_item_row(12'd254, 0, '0, '0);
      add_cfg_row(lgg_pkg::CSR_GAMMA_EXP, 16'd20480);
      add_item_row(12'd1, 0, '0, '0);
      add_item_row(12'd200, 0, '0, '0);
      add_cfg_row(lgg_pkg::CSR_GAMMA_EXP, 16'd4096);
      add_cfg_row(lgg_pkg::CSR_TABLE_ENTRIES, 16'd3);
      add_item_row(12'd1, 1, 12'd1, 16'd32768);
      add_cfg_row(lgg_pkg::CSR_LIFT_OFFSET, 16'h1800);
      add_item_row(12'd0, 1, 12'd0, 16'd0);
      add_item_row(12'd1, 1, 12'd1, 16'd0);
      add_item_row(12'd2, 0, '0, '0);
      add_cfg_row(lgg_pkg::CSR_GAMMA_EXP, 16'd0);
      add_item_row(12'd2, 1, 12'd2, 16'd65535);
      add_item_row(12'd0, 1, 12'd0, 16'd0);
      add_cfg_row(lgg_pkg::CSR_GAMMA_EXP, 16'h7fff);
      add_cfg_row(lgg_pkg::CSR_LIFT_OFFSET, 16'h0800);
      add_cfg_row(lgg_pkg::CSR_GAIN_SCALE, 16'h1fff);
      add_cfg_row(lgg_pkg::CSR_RED_MULT, 16'd0);
      add_cfg_row(lgg_pkg::CSR_GREEN_MULT, 16'hffff);
      add_cfg_row(lgg_pkg::CSR_BLUE_MULT, 16'd2048);
      add_item_row(12'd0, 0, '0, '0);
      add_item_row(12'd2, 0, '0, '0);
      add_cfg_row(lgg_pkg::CSR_TABLE_ENTRIES, 16'd0);
      add_item_row(12'd4095, 0, '0, '0);
      add_cfg_row(lgg_pkg::CSR_TABLE_ENTRIES, 16'h1fff);
      add_item_row(12'd4095, 0, '0, '0);
      add_cfg_row(CSR_UNUSED, 16'hffff);
      add_item_row(12'd17, 0, '0, '0);
      add_item_row(12'd2730, 0, '0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_cfg) begin
            drain_pipe();
            write_csr(row.cidx, row.cdata);
         end else begin
            send_entry(row.idx, row.known, row.want);
         end
      end

      // random phases, each with a fresh register setting
      for (int ph = 0; ph < 11; ph++) begin
         drain_pipe();
         idle_on = (ph != 4);
         mode = (ph < 2) ? ph : 2;
         write_csr(lgg_pkg::CSR_GAMMA_EXP, pick_q12(819, 20480, mode));
         write_csr(lgg_pkg::CSR_LIFT_OFFSET, (mode == 2 && $urandom_range(99) >= 5) ?
                   16'($urandom_range(4096) - 2048) : pick_q12(-2048, 2048, mode));
         write_csr(lgg_pkg::CSR_GAIN_SCALE, pick_q12(2048, 6144, mode));
         write_csr(lgg_pkg::CSR_RED_MULT, pick_q12(2048, 6144, mode));
         write_csr(lgg_pkg::CSR_GREEN_MULT, pick_q12(2048, 6144, mode));
         write_csr(lgg_pkg::CSR_BLUE_MULT, pick_q12(2048, 6144, mode));
         write_csr(lgg_pkg::CSR_TABLE_ENTRIES, pick_q12(2, 4096, mode));
         if ($urandom_range(3) == 0) write_csr(CSR_UNUSED, 16'($urandom));
         n = int'(cur_entries);
         if (n < 2) n = 2;
         if (n > MAX_ENTRIES) n = MAX_ENTRIES;
         for (int k = 0; k < 150; k++) begin
            if ($urandom_range(99) < 15) idx = 12'($urandom);
            else idx = 12'($urandom_range(n - 1));
            send_entry(idx, 0, '{default: '0});
         end
      end

      drain_pipe();
      if (fail_count == 0) begin
         $display("lift_gamma_gain_lut_gen test passed");
      end else begin
         $display("lift_gamma_gain_lut_gen test failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/lgg_pkg.sv
hdl/lift_gamma_gain_lut_gen.sv
dv/tb_lift_gamma_gain_lut_gen.sv
